// File: sv/snu_pkg.sv
// snu_pkg: shared types, register codes and fixed widths for the spiking neuron update block.
// No dependencies; every other file refers to it by scoped names.
package snu_pkg;

   // magnitude of a clamped state and width of a cooldown quotient
   localparam int QUOT_W   = 17;
   // effective divisor: cooldown_divisor floored at 1.0, which may need bit 16
   localparam int DVS_W    = 17;
   // partial remainder of the restoring divider
   localparam int REM_W    = DVS_W + 1;
   localparam int PROD_W   = 32;
   localparam int WEIGHT_W = 24;
   localparam int PATH_SHIFT = 5;
   localparam int PATH_W   = 32 - PATH_SHIFT;
   // input register, decision stage, multiply stage, divider steps, output register
   localparam int LATENCY  = QUOT_W + 4;

   localparam logic        OUTPUT_MODE_RESET       = 1'b0;
   localparam logic [15:0] SPIKE_POTENTIAL_RESET   = 16'd25600;
   localparam logic [7:0]  REFRACTORY_PERIOD_RESET = 8'd2;
   localparam logic [15:0] FORWARD_GAIN_RESET      = 16'd256;
   localparam logic [15:0] COOLDOWN_DIVISOR_RESET  = 16'd768;

   typedef enum logic [2:0] {
      REG_OUTPUT_MODE       = 3'd0,
      REG_SPIKE_POTENTIAL   = 3'd1,
      REG_REFRACTORY_PERIOD = 3'd2,
      REG_FORWARD_GAIN      = 3'd3,
      REG_COOLDOWN_DIVISOR  = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic        output_mode;
      logic [15:0] spike_potential;
      logic [7:0]  refractory_period;
      logic [15:0] forward_gain;
      logic [15:0] cooldown_divisor;
   } cfg_type;

   // fields that ride alongside the divider lanes
   typedef struct packed {
      logic              output_mode;
      logic [15:0]       held_pot;
      logic [7:0]        refractory;
      logic              active;
      logic              too_high;
      logic              spike_valid;
      logic [PROD_W-1:0] product;
      logic [15:0]       axon;
      logic [PATH_W-1:0] path;
   } side_type;

endpackage

// File: sv/spiking_neuron_update.sv
// spiking_neuron_update: top level of the leaky integrate-and-fire neuron update pipeline.
// Depends on snu_pkg, snu_cfg, snu_front and snu_divider.
//
//   channel   ports                         handshake              beat
//   -------   ---------------------------   --------------------   --------------------------
//   request   start, busy, req_*            start && !busy         one neuron record
//   response  rsp_valid, rsp_*              rsp_valid (strobe)     updated record plus spike
//   config    csr_valid, csr_ready, csr_*   csr_valid && csr_ready one register write
//
// One neuron enters per clock while busy is low; each beat's response strobes
// after it passes the input register, decision stage, gain multiply stage,
// 17 one-bit steps of the cooldown divider and the output register.
// The divider yields one quotient bit per stage for each lane.
// busy follows reset and is otherwise low; the pipeline never stalls since
// the receiver cannot hold responses off. Reset clears only the valid bits
// and the configuration registers.
// Write configuration only with no beats in flight.
module spiking_neuron_update #(
   parameter int FRAC_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   // request
   input  logic                        start,
   output logic                        busy,
   input  logic signed [17:0]          req_membrane_state,
   input  logic [15:0]                 req_fire_threshold,
   input  logic [15:0]                 req_held_potential,
   input  logic [7:0]                  req_refractory_left,
   input  logic                        req_was_active,
   input  logic [15:0]                 req_axon_id,
   input  logic [31:0]                 req_brick_path,
   // response
   output logic                        rsp_valid,
   output logic [15:0]                 rsp_next_state,
   output logic [15:0]                 rsp_next_potential,
   output logic [7:0]                  rsp_next_refractory,
   output logic                        rsp_next_active,
   output logic                        rsp_too_high,
   output logic                        rsp_spike_valid,
   output logic [23:0]                 rsp_spike_weight,
   output logic [15:0]                 rsp_spike_axon,
   output logic [26:0]                 rsp_spike_path,
   // configuration
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [2:0]                  csr_index,
   input  logic [15:0]                 csr_wdata
);

   snu_pkg::cfg_type            cfg;
   logic [snu_pkg::DVS_W-1:0]   divisor;

   // hold off requests while in reset
   assign busy = reset;

   snu_cfg #(
      .FRAC_BITS (FRAC_BITS)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .divisor   (divisor)
   );

   logic                       fr_valid;
   logic [snu_pkg::QUOT_W-1:0] fr_state;
   logic [15:0]                fr_pot;
   snu_pkg::side_type          fr_side;

   snu_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (start && !busy),
      .membrane_state  (req_membrane_state),
      .fire_threshold  (req_fire_threshold),
      .held_potential  (req_held_potential),
      .refractory_left (req_refractory_left),
      .was_active      (req_was_active),
      .axon_id         (req_axon_id),
      .brick_path      (req_brick_path),
      .cfg             (cfg),
      .out_valid       (fr_valid),
      .out_state       (fr_state),
      .out_pot         (fr_pot),
      .out_side        (fr_side)
   );

   logic                       dv_valid;
   logic [snu_pkg::QUOT_W-1:0] dv_qs, dv_qp;
   snu_pkg::side_type          dv_side;

   snu_divider #(
      .FRAC_BITS (FRAC_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_state  (fr_state),
      .in_pot    (fr_pot),
      .in_side   (fr_side),
      .divisor   (divisor),
      .out_valid (dv_valid),
      .out_qs    (dv_qs),
      .out_qp    (dv_qp),
      .out_side  (dv_side)
   );

   // output stage: saturate quotients and the forwarded weight
   logic [snu_pkg::PROD_W-1:0] wshift;
   logic [15:0]                state_in, pot_in;
   logic [23:0]                weight_in;

   always_comb begin
      state_in = dv_qs[snu_pkg::QUOT_W-1] ? 16'hFFFF : dv_qs[15:0];
      // output mode passes the potential through uncooled
      if (dv_side.output_mode) begin
         pot_in = dv_side.held_pot;
      end else begin
         pot_in = dv_qp[snu_pkg::QUOT_W-1] ? 16'hFFFF : dv_qp[15:0];
      end
      wshift = dv_side.product >> FRAC_BITS;
      if (!dv_side.spike_valid) begin
         weight_in = '0;
      end else if (|wshift[snu_pkg::PROD_W-1:snu_pkg::WEIGHT_W]) begin
         weight_in = '1;
      end else begin
         weight_in = wshift[snu_pkg::WEIGHT_W-1:0];
      end
   end

   logic        rsp_valid_ff;
   logic [15:0] state_ff, pot_ff, axon_ff;
   logic [7:0]  refr_ff;
   logic        active_ff, high_ff, spike_ff;
   logic [23:0] weight_ff;
   logic [26:0] path_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      state_ff  <= state_in;
      pot_ff    <= pot_in;
      refr_ff   <= dv_side.refractory;
      active_ff <= dv_side.active;
      high_ff   <= dv_side.too_high;
      spike_ff  <= dv_side.spike_valid;
      weight_ff <= weight_in;
      axon_ff   <= dv_side.axon;
      path_ff   <= dv_side.path;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_next_state      = state_ff;
   assign rsp_next_potential  = pot_ff;
   assign rsp_next_refractory = refr_ff;
   assign rsp_next_active     = active_ff;
   assign rsp_too_high        = high_ff;
   assign rsp_spike_valid     = spike_ff;
   assign rsp_spike_weight    = weight_ff;
   assign rsp_spike_axon      = axon_ff;
   assign rsp_spike_path      = path_ff;

endmodule

// File: sv/snu_cfg.sv
// snu_cfg: configuration registers written through the csr_ channel.
// Depends on snu_pkg for register codes, reset values and the config struct.
module snu_cfg #(
   parameter int FRAC_BITS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [2:0]                 csr_index,
   input  logic [15:0]                csr_wdata,
   output snu_pkg::cfg_type           cfg,
   output logic [snu_pkg::DVS_W-1:0]  divisor
);

   localparam logic [snu_pkg::DVS_W-1:0] ONE_FX = snu_pkg::DVS_W'(1) << FRAC_BITS;

   snu_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            snu_pkg::REG_OUTPUT_MODE:       cfg_in.output_mode       = csr_wdata[0];
            snu_pkg::REG_SPIKE_POTENTIAL:   cfg_in.spike_potential   = csr_wdata;
            snu_pkg::REG_REFRACTORY_PERIOD: cfg_in.refractory_period = csr_wdata[7:0];
            snu_pkg::REG_FORWARD_GAIN:      cfg_in.forward_gain      = csr_wdata;
            snu_pkg::REG_COOLDOWN_DIVISOR:  cfg_in.cooldown_divisor  = csr_wdata;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.output_mode       <= snu_pkg::OUTPUT_MODE_RESET;
         cfg_ff.spike_potential   <= snu_pkg::SPIKE_POTENTIAL_RESET;
         cfg_ff.refractory_period <= snu_pkg::REFRACTORY_PERIOD_RESET;
         cfg_ff.forward_gain      <= snu_pkg::FORWARD_GAIN_RESET;
         cfg_ff.cooldown_divisor  <= snu_pkg::COOLDOWN_DIVISOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   // a divisor below 1.0 acts as 1.0
   always_comb begin
      if (snu_pkg::DVS_W'(cfg_ff.cooldown_divisor) < ONE_FX) begin
         divisor = ONE_FX;
      end else begin
         divisor = snu_pkg::DVS_W'(cfg_ff.cooldown_divisor);
      end
   end

endmodule

// File: sv/snu_front.sv
// snu_front: input register, clamp and fire decision stage, gain multiply stage.
// Depends on snu_pkg for widths and the sideband struct.
module snu_front #(
   parameter int FRAC_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic signed [17:0]          membrane_state,
   input  logic [15:0]                 fire_threshold,
   input  logic [15:0]                 held_potential,
   input  logic [7:0]                  refractory_left,
   input  logic                        was_active,
   input  logic [15:0]                 axon_id,
   input  logic [31:0]                 brick_path,
   input  snu_pkg::cfg_type            cfg,
   output logic                        out_valid,
   output logic [snu_pkg::QUOT_W-1:0]  out_state,
   output logic [15:0]                 out_pot,
   output snu_pkg::side_type           out_side
);

   localparam int CW = snu_pkg::QUOT_W + FRAC_BITS;
   localparam logic [CW-1:0] STATE_CAP = CW'(255) << FRAC_BITS;

   // input register
   logic               v1_ff;
   logic signed [17:0] st1_ff;
   logic [15:0]        thr1_ff, pot1_ff, axon1_ff;
   logic [7:0]         refr1_ff;
   logic               act1_ff;
   logic [31:0]        path1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      st1_ff   <= membrane_state;
      thr1_ff  <= fire_threshold;
      pot1_ff  <= held_potential;
      refr1_ff <= refractory_left;
      act1_ff  <= was_active;
      axon1_ff <= axon_id;
      path1_ff <= brick_path;
   end

   // decision stage
   logic                       neg, capped, rdy, fire, spike;
   logic [snu_pkg::QUOT_W-1:0] s17, mag2_in;
   logic [15:0]                pot2_in, axon2_in;
   logic [7:0]                 refr_n, refr2_in;
   logic                       act2_in;
   logic [snu_pkg::PATH_W-1:0] path2_in;

   always_comb begin
      neg    = st1_ff[17];
      s17    = st1_ff[snu_pkg::QUOT_W-1:0];
      capped = !cfg.output_mode && (CW'(s17) > STATE_CAP);
      if (neg) begin
         mag2_in = '0;
      end else if (capped) begin
         mag2_in = STATE_CAP[snu_pkg::QUOT_W-1:0];
      end else begin
         mag2_in = s17;
      end
      rdy    = (refr1_ff == 8'd0);
      fire   = !cfg.output_mode && rdy && !neg
               && ({1'b0, thr1_ff} <= mag2_in);
      pot2_in = fire ? cfg.spike_potential : pot1_ff;
      refr_n  = fire ? cfg.refractory_period : refr1_ff;
      if (cfg.output_mode) begin
         act2_in  = act1_ff;
         refr2_in = refr1_ff;
      end else begin
         act2_in  = rdy ? fire : act1_ff;
         refr2_in = (refr_n != 8'd0) ? refr_n - 8'd1 : 8'd0;
      end
      spike    = !cfg.output_mode && act2_in;
      axon2_in = spike ? axon1_ff : 16'd0;
      path2_in = spike ? path1_ff[31:snu_pkg::PATH_SHIFT] : '0;
   end

   logic                       v2_ff, mode2_ff, act2_ff, spike2_ff;
   logic [snu_pkg::QUOT_W-1:0] mag2_ff;
   logic [15:0]                thr2_ff, pot2_ff, axon2_ff;
   logic [7:0]                 refr2_ff;
   logic [snu_pkg::PATH_W-1:0] path2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      mode2_ff  <= cfg.output_mode;
      act2_ff   <= act2_in;
      spike2_ff <= spike;
      mag2_ff   <= mag2_in;
      thr2_ff   <= thr1_ff;
      pot2_ff   <= pot2_in;
      axon2_ff  <= axon2_in;
      refr2_ff  <= refr2_in;
      path2_ff  <= path2_in;
   end

   // multiply and too-high stage: 5*s > 6*t is the exact 1.2x test
   logic [19:0]       s5, t6;
   snu_pkg::side_type side3_in;

   always_comb begin
      s5 = (20'(mag2_ff) << 2) + 20'(mag2_ff);
      t6 = (20'(thr2_ff) << 2) + (20'(thr2_ff) << 1);
      side3_in.output_mode = mode2_ff;
      side3_in.held_pot    = pot2_ff;
      side3_in.refractory  = refr2_ff;
      side3_in.active      = act2_ff;
      side3_in.too_high    = !mode2_ff && (s5 > t6);
      side3_in.spike_valid = spike2_ff;
      side3_in.product     = snu_pkg::PROD_W'(pot2_ff) * snu_pkg::PROD_W'(cfg.forward_gain);
      side3_in.axon        = axon2_ff;
      side3_in.path        = path2_ff;
   end

   logic                       v3_ff;
   logic [snu_pkg::QUOT_W-1:0] mag3_ff;
   logic [15:0]                pot3_ff;
   snu_pkg::side_type          side3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      mag3_ff  <= mag2_ff;
      pot3_ff  <= pot2_ff;
      side3_ff <= side3_in;
   end

   assign out_valid = v3_ff;
   assign out_state = mag3_ff;
   assign out_pot   = pot3_ff;
   assign out_side  = side3_ff;

endmodule

// File: sv/snu_divider.sv
// snu_divider: two-lane pipelined restoring divider, one quotient bit per stage.
// Computes (value << FRAC_BITS) / divisor for state and potential; depends on snu_pkg.
module snu_divider #(
   parameter int FRAC_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [snu_pkg::QUOT_W-1:0]  in_state,
   input  logic [15:0]                 in_pot,
   input  snu_pkg::side_type           in_side,
   input  logic [snu_pkg::DVS_W-1:0]   divisor,
   output logic                        out_valid,
   output logic [snu_pkg::QUOT_W-1:0]  out_qs,
   output logic [snu_pkg::QUOT_W-1:0]  out_qp,
   output snu_pkg::side_type           out_side
);

   localparam int QW = snu_pkg::QUOT_W;
   localparam int RW = snu_pkg::REM_W;
   localparam int DW = QW + FRAC_BITS;

   // divisor is at least 1.0, so the top FRAC_BITS quotient bits are zero:
   // seed the remainder with the top FRAC_BITS dividend bits
   logic [DW-1:0] ds, dp;
   logic [RW-1:0] rs0, rp0;
   logic [QW-1:0] bs0, bp0;

   always_comb begin
      ds  = {in_state, {FRAC_BITS{1'b0}}};
      dp  = {1'b0, in_pot, {FRAC_BITS{1'b0}}};
      rs0 = RW'(ds[DW-1:QW]);
      rp0 = RW'(dp[DW-1:QW]);
      bs0 = ds[QW-1:0];
      bp0 = dp[QW-1:0];
   end

   logic              vld_ff  [QW];
   logic [RW-1:0]     rs_ff   [QW];
   logic [RW-1:0]     rp_ff   [QW];
   logic [QW-1:0]     bs_ff   [QW];
   logic [QW-1:0]     bp_ff   [QW];
   logic [QW-1:0]     qs_ff   [QW];
   logic [QW-1:0]     qp_ff   [QW];
   snu_pkg::side_type side_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic              v_prev;
      logic [RW-1:0]     rs_prev, rp_prev, rs_sh, rp_sh, rs_in, rp_in;
      logic [QW-1:0]     bs_prev, bp_prev, qs_prev, qp_prev;
      logic              ges, gep;
      snu_pkg::side_type sd_prev;

      if (k == 0) begin : g_first
         assign v_prev  = in_valid;
         assign rs_prev = rs0;
         assign rp_prev = rp0;
         assign bs_prev = bs0;
         assign bp_prev = bp0;
         assign qs_prev = '0;
         assign qp_prev = '0;
         assign sd_prev = in_side;
      end else begin : g_next
         assign v_prev  = vld_ff[k-1];
         assign rs_prev = rs_ff[k-1];
         assign rp_prev = rp_ff[k-1];
         assign bs_prev = bs_ff[k-1];
         assign bp_prev = bp_ff[k-1];
         assign qs_prev = qs_ff[k-1];
         assign qp_prev = qp_ff[k-1];
         assign sd_prev = side_ff[k-1];
      end

      always_comb begin
         rs_sh = {rs_prev[RW-2:0], bs_prev[QW-1]};
         rp_sh = {rp_prev[RW-2:0], bp_prev[QW-1]};
         ges   = rs_sh >= {1'b0, divisor};
         gep   = rp_sh >= {1'b0, divisor};
         rs_in = ges ? rs_sh - {1'b0, divisor} : rs_sh;
         rp_in = gep ? rp_sh - {1'b0, divisor} : rp_sh;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         rs_ff[k]   <= rs_in;
         rp_ff[k]   <= rp_in;
         bs_ff[k]   <= {bs_prev[QW-2:0], 1'b0};
         bp_ff[k]   <= {bp_prev[QW-2:0], 1'b0};
         qs_ff[k]   <= {qs_prev[QW-2:0], ges};
         qp_ff[k]   <= {qp_prev[QW-2:0], gep};
         side_ff[k] <= sd_prev;
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_qs    = qs_ff[QW-1];
   assign out_qp    = qp_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

// File: sv/snu_checker.sv
// snu_checker: port-level assertions for spiking_neuron_update, bound to the top level.
// Depends on snu_pkg for the pipeline latency.
module snu_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [15:0] req_axon_id,
   input logic        rsp_valid,
   input logic        rsp_next_active,
   input logic        rsp_spike_valid,
   input logic [23:0] rsp_spike_weight,
   input logic [15:0] rsp_spike_axon,
   input logic [26:0] rsp_spike_path
);

   // every response strobe matches an earlier request beat
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, snu_pkg::LATENCY))
      else $error("response without a matching request");

   // a spike is only forwarded by an active neuron
   a_spike_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_spike_valid) |-> rsp_next_active)
      else $error("spike from an inactive neuron");

   // no spike means all spike fields are zero
   a_no_spike_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_spike_valid) |->
         (rsp_spike_weight == 24'd0 && rsp_spike_axon == 16'd0 && rsp_spike_path == 27'd0))
      else $error("spike fields set without a spike");

   // a spike goes to the axon of the record it came from
   a_spike_axon: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_spike_valid) |->
         (rsp_spike_axon == $past(req_axon_id, snu_pkg::LATENCY)))
      else $error("spike axon does not match its request");

endmodule

bind spiking_neuron_update snu_checker u_snu_checker (.*);

// File: tb/tb_spiking_neuron_update.sv
// Self-checking testbench for spiking_neuron_update: directed neuron records, then random ones.
// The records run under several register settings, with the updates checked against an inline
// predictor. Depends on snu_pkg and the spiking_neuron_update RTL.
`timescale 1ns / 100ps

module tb_spiking_neuron_update;

   localparam int FRAC_BITS = 8;
   localparam longint ONE_FX = longint'(1) << FRAC_BITS;
   localparam longint STATE_CAP = longint'(255) << FRAC_BITS;
   localparam logic [2:0] FIRST_UNUSED_REG = 3'(snu_pkg::REG_COOLDOWN_DIVISOR) + 3'd1;
   localparam logic [2:0] LAST_REG_CODE = '1;
   localparam int NUM_PHASES = 12;
   localparam int PHASE_NEURONS = 150;

   // one neuron record as it enters the block
   typedef struct packed {
      logic [17:0] membrane_state;
      logic [15:0] fire_threshold;
      logic [15:0] held_potential;
      logic [7:0]  refractory_left;
      logic        was_active;
      logic [15:0] axon_id;
      logic [31:0] brick_path;
   } neuron_type;

   // updated record plus spike, as it leaves the block
   typedef struct packed {
      logic [15:0] next_state;
      logic [15:0] next_potential;
      logic [7:0]  next_refractory;
      logic        next_active;
      logic        too_high;
      logic        spike_valid;
      logic [23:0] spike_weight;
      logic [15:0] spike_axon;
      logic [26:0] spike_path;
   } update_type;

   // Tracks the register copy and the updates still owed by the block.
   class neuron_update_tracker;
      snu_pkg::cfg_type cfg;
      update_type       pending_updates[$];
      int               mismatches;

      function new();
         cfg.output_mode       = snu_pkg::OUTPUT_MODE_RESET;
         cfg.spike_potential   = snu_pkg::SPIKE_POTENTIAL_RESET;
         cfg.refractory_period = snu_pkg::REFRACTORY_PERIOD_RESET;
         cfg.forward_gain      = snu_pkg::FORWARD_GAIN_RESET;
         cfg.cooldown_divisor  = snu_pkg::COOLDOWN_DIVISOR_RESET;
         mismatches = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [15:0] data);
         case (idx)
            snu_pkg::REG_OUTPUT_MODE:       cfg.output_mode       = data[0];
            snu_pkg::REG_SPIKE_POTENTIAL:   cfg.spike_potential   = data;
            snu_pkg::REG_REFRACTORY_PERIOD: cfg.refractory_period = data[7:0];
            snu_pkg::REG_FORWARD_GAIN:      cfg.forward_gain      = data;
            snu_pkg::REG_COOLDOWN_DIVISOR:  cfg.cooldown_divisor  = data;
            default: ;
         endcase
      endfunction

      // divide by the cooldown, which never counts as less than 1.0
      function longint cooled(longint v);
         longint d;
         d = cfg.cooldown_divisor;
         if (d < ONE_FX) d = ONE_FX;
         if (v < 0) return 0;
         v = (v << FRAC_BITS) / d;
         return (v > 65535) ? 65535 : v;
      endfunction

      function update_type predict_update(neuron_type n);
         update_type u;
         longint     st;
         longint     thr;
         longint     pot;
         longint     refr;
         longint     w;
         logic       act;
         u    = '0;
         st   = $signed(n.membrane_state);
         thr  = n.fire_threshold;
         pot  = n.held_potential;
         refr = n.refractory_left;
         act  = n.was_active;
         if (cfg.output_mode) begin
            u.next_state      = 16'(cooled(st));
            u.next_potential  = n.held_potential;
            u.next_refractory = n.refractory_left;
            u.next_active     = act;
            return u;
         end
         if (st > STATE_CAP) st = STATE_CAP;
         if (refr == 0) begin
            if (thr <= st) begin
               pot  = cfg.spike_potential;
               act  = 1'b1;
               refr = cfg.refractory_period;
            end else begin
               act = 1'b0;
            end
         end
         if (act) begin
            w = (pot * longint'(cfg.forward_gain)) >> FRAC_BITS;
            u.spike_valid  = 1'b1;
            u.spike_weight = (w > 64'hFF_FFFF) ? 24'hFF_FFFF : 24'(w);
            u.spike_axon   = n.axon_id;
            u.spike_path   = 27'(n.brick_path >> snu_pkg::PATH_SHIFT);
         end
         if (refr != 0) refr--;
         if (st < 0) st = 0;
         u.too_high        = (st * 5 > thr * 6);
         u.next_state      = 16'(cooled(st));
         u.next_potential  = 16'(cooled(pot));
         u.next_refractory = 8'(refr);
         u.next_active     = act;
         return u;
      endfunction

      function void note_neuron(neuron_type n);
         pending_updates.push_back(predict_update(n));
      endfunction

      function void check_field(string name, longint unsigned e, longint unsigned a);
         if (e != a) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, e, a);
            mismatches++;
         end
      endfunction

      function void check_update(update_type a);
         update_type e;
         if (pending_updates.size() == 0) begin
            $display("%0t: update with none expected, actual %h", $time, a);
            mismatches++;
            return;
         end
         e = pending_updates.pop_front();
         check_field("next_state", e.next_state, a.next_state);
         check_field("next_potential", e.next_potential, a.next_potential);
         check_field("next_refractory", e.next_refractory, a.next_refractory);
         check_field("next_active", e.next_active, a.next_active);
         check_field("too_high", e.too_high, a.too_high);
         check_field("spike_valid", e.spike_valid, a.spike_valid);
         check_field("spike_weight", e.spike_weight, a.spike_weight);
         check_field("spike_axon", e.spike_axon, a.spike_axon);
         check_field("spike_path", e.spike_path, a.spike_path);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [17:0] req_membrane_state = '0;
   logic [15:0] req_fire_threshold = '0;
   logic [15:0] req_held_potential = '0;
   logic [7:0]  req_refractory_left = '0;
   logic        req_was_active = 1'b0;
   logic [15:0] req_axon_id = '0;
   logic [31:0] req_brick_path = '0;
   logic        rsp_valid;
   logic [15:0] rsp_next_state;
   logic [15:0] rsp_next_potential;
   logic [7:0]  rsp_next_refractory;
   logic        rsp_next_active;
   logic        rsp_too_high;
   logic        rsp_spike_valid;
   logic [23:0] rsp_spike_weight;
   logic [15:0] rsp_spike_axon;
   logic [26:0] rsp_spike_path;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   neuron_update_tracker sb;
   update_type           observed;
   // clear to run back-to-back beats with no gaps
   bit                   idle_on = 1'b1;

   spiking_neuron_update #(
      .FRAC_BITS(FRAC_BITS)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_membrane_state (req_membrane_state),
      .req_fire_threshold (req_fire_threshold),
      .req_held_potential (req_held_potential),
      .req_refractory_left(req_refractory_left),
      .req_was_active     (req_was_active),
      .req_axon_id        (req_axon_id),
      .req_brick_path     (req_brick_path),
      .rsp_valid          (rsp_valid),
      .rsp_next_state     (rsp_next_state),
      .rsp_next_potential (rsp_next_potential),
      .rsp_next_refractory(rsp_next_refractory),
      .rsp_next_active    (rsp_next_active),
      .rsp_too_high       (rsp_too_high),
      .rsp_spike_valid    (rsp_spike_valid),
      .rsp_spike_weight   (rsp_spike_weight),
      .rsp_spike_axon     (rsp_spike_axon),
      .rsp_spike_path     (rsp_spike_path),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // The receiver cannot stall, so every strobe is a beat: check it on the spot.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         observed.next_state      = rsp_next_state;
         observed.next_potential  = rsp_next_potential;
         observed.next_refractory = rsp_next_refractory;
         observed.next_active     = rsp_next_active;
         observed.too_high        = rsp_too_high;
         observed.spike_valid     = rsp_spike_valid;
         observed.spike_weight    = rsp_spike_weight;
         observed.spike_axon      = rsp_spike_axon;
         observed.spike_path      = rsp_spike_path;
         sb.check_update(observed);
      end
   end

   function automatic neuron_type make_neuron(int state, logic [15:0] thr, logic [15:0] pot,
                                              logic [7:0] refr, logic act, logic [15:0] axon,
                                              logic [31:0] path);
      neuron_type n;
      n.membrane_state  = 18'(state);
      n.fire_threshold  = thr;
      n.held_potential  = pot;
      n.refractory_left = refr;
      n.was_active      = act;
      n.axon_id         = axon;
      n.brick_path      = path;
      return n;
   endfunction

   // Mostly states near the firing border or the too-high border, the rest raw noise.
   function automatic neuron_type random_neuron();
      neuron_type   n;
      logic [127:0] noise;
      int           kind;
      int           offs;
      noise = {$urandom, $urandom, $urandom, $urandom};
      n     = noise[$bits(neuron_type)-1:0];
      kind  = $urandom_range(9, 0);
      offs  = int'($urandom_range(64, 0)) - 32;
      if (kind >= 2) begin
         if (kind == 9) n.fire_threshold = 16'($urandom_range(300, 0));
         if (kind < 6) n.membrane_state = 18'(int'(n.fire_threshold) + offs);
         else n.membrane_state = 18'(int'(n.fire_threshold) * 6 / 5 + offs);
         n.refractory_left = ($urandom_range(1, 0) == 1) ? 8'd0 : 8'($urandom_range(3, 1));
      end
      return n;
   endfunction

   // Hold start high until the block takes the beat; drop it only across a gap.
   task automatic send_neuron(neuron_type n);
      int gap;
      gap = idle_on ? $urandom_range(8, 0) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start               <= 1'b1;
      req_membrane_state  <= n.membrane_state;
      req_fire_threshold  <= n.fire_threshold;
      req_held_potential  <= n.held_potential;
      req_refractory_left <= n.refractory_left;
      req_was_active      <= n.was_active;
      req_axon_id         <= n.axon_id;
      req_brick_path      <= n.brick_path;
      do @(posedge clock); while (busy);
      sb.note_neuron(n);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [15:0] data);
      int gap;
      gap = idle_on ? $urandom_range(8, 0) : 0;
      if (gap > 0) begin
         csr_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
   endtask

   // Every update is owed, so an empty store means nothing is in flight.
   task automatic drain_updates();
      start <= 1'b0;
      while (sb.pending_updates.size() != 0) @(posedge clock);
   endtask

   // Write every register, with junk in the unused upper bits, plus one unused index.
   task automatic configure(logic mode, logic [15:0] ap, logic [7:0] rp, logic [15:0] gain,
                            logic [15:0] div);
      drain_updates();
      write_csr(snu_pkg::REG_OUTPUT_MODE, {15'($urandom), mode});
      write_csr(snu_pkg::REG_SPIKE_POTENTIAL, ap);
      write_csr(snu_pkg::REG_REFRACTORY_PERIOD, {8'($urandom), rp});
      write_csr(snu_pkg::REG_FORWARD_GAIN, gain);
      write_csr(snu_pkg::REG_COOLDOWN_DIVISOR, div);
      write_csr(3'($urandom_range(LAST_REG_CODE, FIRST_UNUSED_REG)), 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Lean toward the ends of a register's range.
   function automatic logic [15:0] pick_value(logic [15:0] lo, logic [15:0] hi);
      case ($urandom_range(3, 0))
         0: return lo;
         1: return hi;
         default: return 16'($urandom_range(hi, lo));
      endcase
   endfunction

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: clamping, the firing border, refractory hold and too-high edge
      send_neuron(make_neuron(131071, 16'd0, 16'd0, 8'd0, 1'b0, 16'd0, 32'd0));
      send_neuron(make_neuron(-131072, 16'd0, 16'hFFFF, 8'd0, 1'b1, 16'hFFFF, 32'hFFFF_FFFF));
      send_neuron(make_neuron(-1, 16'd0, 16'd1234, 8'd0, 1'b1, 16'd7, 32'd99));
      send_neuron(make_neuron(12800, 16'd12800, 16'd1000, 8'd0, 1'b0, 16'h1234, 32'h1F));
      send_neuron(make_neuron(12799, 16'd12800, 16'd1000, 8'd0, 1'b1, 16'h1234, 32'h20));
      send_neuron(make_neuron(30000, 16'd100, 16'd40000, 8'd3, 1'b1, 16'hA5A5,
                              32'hDEAD_BEEF));
      send_neuron(make_neuron(30000, 16'd100, 16'd40000, 8'd1, 1'b0, 16'h5A5A, 32'h1234_5678));
      send_neuron(make_neuron(65280, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 16'hFFFF,
                              32'hFFFF_FFFF));
      send_neuron(make_neuron(65281, 16'hFFFF, 16'd500, 8'd0, 1'b1, 16'd3, 32'd64));
      send_neuron(make_neuron(600, 16'd500, 16'd0, 8'd5, 1'b0, 16'd0, 32'd0));
      send_neuron(make_neuron(601, 16'd500, 16'd0, 8'd5, 1'b0, 16'd0, 32'd0));
      send_neuron(make_neuron(0, 16'd0, 16'd0, 8'd0, 1'b0, 16'd0, 32'd0));

      // output brick with a divisor below 1.0: negative and oversized states
      configure(1'b1, snu_pkg::SPIKE_POTENTIAL_RESET, snu_pkg::REFRACTORY_PERIOD_RESET,
                snu_pkg::FORWARD_GAIN_RESET, 16'd0);
      send_neuron(make_neuron(-131072, 16'd0, 16'hFFFF, 8'hFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF));
      send_neuron(make_neuron(-1, 16'd10, 16'd300, 8'd0, 1'b0, 16'd1, 32'd1));
      send_neuron(make_neuron(131071, 16'd0, 16'd77, 8'd4, 1'b1, 16'd2, 32'd2));
      send_neuron(make_neuron(65535, 16'hFFFF, 16'd0, 8'd0, 1'b0, 16'd0, 32'd0));
      send_neuron(make_neuron(0, 16'd0, 16'd0, 8'd0, 1'b0, 16'd0, 32'd0));

      for (int p = 0; p < NUM_PHASES; p++) begin
         idle_on = (p % 4 != 3);
         if (p == 0)
            configure(1'b0, 16'hFFFF, 8'hFF, 16'hFFFF, 16'd0);
         else if (p == 1)
            configure(1'b0, 16'd0, 8'd0, 16'd0, 16'hFFFF);
         else if (p == 2)
            configure(1'b1, 16'd0, 8'd0, 16'd0, 16'd255);
         else
            configure($urandom_range(3, 0) == 0, pick_value(16'd0, 16'hFFFF),
                      8'(pick_value(16'd0, 16'd255)), pick_value(16'd0, 16'hFFFF),
                      pick_value(16'd0, 16'hFFFF));
         repeat (PHASE_NEURONS) send_neuron(random_neuron());
      end

      drain_updates();
      repeat (snu_pkg::LATENCY + 4) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_updates.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: spiking_neuron_update.f
sv/snu_pkg.sv
sv/snu_cfg.sv
sv/snu_front.sv
sv/snu_divider.sv
sv/spiking_neuron_update.sv
sv/snu_checker.sv
tb/tb_spiking_neuron_update.sv
